@@ hw/rtl/mpa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpa_pkg
// Shared types and constants for the max pool with argmax unit.
// ----------------------------------------------------------------------------
package mpa_pkg;

  localparam int MAX_HEIGHT   = 64;
  localparam int MAX_WIDTH    = 64;
  localparam int MAX_CHANNELS = 16;

  localparam int POS_W       = 12;
  localparam int CELL_W      = 14;
  localparam int CHAN_W      = 4;
  localparam int RESULT_W    = 16;
  localparam int POOL_W      = 4;
  localparam int SIZE_W      = 7;
  localparam int CHANS_W     = 5;
  localparam int CFG_DATA_W  = 7;
  localparam int CFG_INDEX_W = 2;
  localparam int PHASE_W     = 3;
  localparam int SPAN_W      = 9;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_POOL_SIZE     = 2'd0,
    REG_IMAGE_HEIGHT  = 2'd1,
    REG_IMAGE_WIDTH   = 2'd2,
    REG_CHANNEL_COUNT = 2'd3
  } reg_index_t;

  localparam logic CMD_FORWARD   = 1'b0;
  localparam logic CMD_BACKWARD  = 1'b1;
  localparam logic KIND_MAX      = 1'b0;
  localparam logic KIND_GRADIENT = 1'b1;

  typedef struct packed {
    logic [POOL_W-1:0]  win_size;
    logic [SIZE_W-1:0]  image_height;
    logic [SIZE_W-1:0]  image_width;
    logic [CHANS_W-1:0] channel_count;
  } mpa_cfg_t;

  typedef struct packed {
    logic backward;
    logic window;
    logic first;
    logic last;
    logic emit;
    logic pass_end;
  } mpa_ctl_t;

endpackage

@@ hw/rtl/mpa_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpa_ram
// Simple dual port RAM, registered read, with write-to-read bypass.
// ----------------------------------------------------------------------------
module mpa_ram #(
  parameter int DEPTH = 32,
  parameter int AW    = 5,
  parameter int DW    = 28
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_q;
  logic [DW-1:0] byp_data;
  logic          byp_hit;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q     <= mem[rd_addr];
      byp_data <= wr_data;
    end
  end

  // same-edge write to the address being read
  always_ff @(posedge clk) begin
    if (rst) begin
      byp_hit <= 1'b0;
    end else if (rd_en) begin
      byp_hit <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = byp_hit ? byp_data : rd_q;

endmodule

@@ hw/rtl/mpa_seq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpa_seq
// Raster, window and cell counters for forward and backward beats.
// ----------------------------------------------------------------------------
module mpa_seq #(
  parameter int ROW_AW       = 5,
  parameter int STORE_AW     = 14,
  parameter int CH_W         = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       clear,
  input  mpa_pkg::mpa_cfg_t          cfg,
  input  logic                       take,
  input  logic                       command,
  output mpa_pkg::mpa_ctl_t          ctl,
  output logic [ROW_AW-1:0]          slot,
  output logic [mpa_pkg::POS_W-1:0]  pos,
  output logic [CH_W-1:0]            channel,
  output logic [STORE_AW-1:0]        cell_idx
);
  import mpa_pkg::*;

  logic [POOL_W-1:0]  p;
  logic [SIZE_W-1:0]  h;
  logic [SIZE_W-1:0]  w;
  logic [CHANS_W-1:0] c;

  logic [SIZE_W-1:0]   f_row, f_row_next, f_col, f_col_next;
  logic [PHASE_W-1:0]  row_ph, row_ph_next, col_ph, col_ph_next;
  logic [ROW_AW-1:0]   wcol, wcol_next;
  logic [POS_W-1:0]    f_pos, f_pos_next;
  logic [CH_W-1:0]     f_ch, f_ch_next, b_ch, b_ch_next;
  logic [STORE_AW-1:0] f_cell, f_cell_next, b_cell, b_cell_next;
  logic [SIZE_W-1:0]   b_row_base, b_row_base_next, b_col_base, b_col_base_next;

  logic [SPAN_W-1:0] p_s, p2_s, h_s, w_s, f_rb, f_cb, b_rb, b_cb;
  logic win, first, last, f_last_row, f_last_col, f_ch_last, f_end;
  logic b_last_row, b_last_col, b_ch_last, b_end, empty;

  always_comb begin
    if (cfg.win_size < POOL_W'(2)) begin
      p = POOL_W'(2);
    end else if (cfg.win_size > POOL_W'(8)) begin
      p = POOL_W'(8);
    end else begin
      p = cfg.win_size;
    end
    if (cfg.image_height == '0) begin
      h = SIZE_W'(1);
    end else if (32'(cfg.image_height) > MAX_HEIGHT) begin
      h = SIZE_W'(MAX_HEIGHT);
    end else begin
      h = cfg.image_height;
    end
    if (cfg.image_width == '0) begin
      w = SIZE_W'(1);
    end else if (32'(cfg.image_width) > MAX_WIDTH) begin
      w = SIZE_W'(MAX_WIDTH);
    end else begin
      w = cfg.image_width;
    end
    if (cfg.channel_count == '0) begin
      c = CHANS_W'(1);
    end else if (32'(cfg.channel_count) > MAX_CHANNELS) begin
      c = CHANS_W'(MAX_CHANNELS);
    end else begin
      c = cfg.channel_count;
    end
  end

  always_comb begin
    p_s  = SPAN_W'(p);
    p2_s = p_s + p_s;
    h_s  = SPAN_W'(h);
    w_s  = SPAN_W'(w);
    f_rb = SPAN_W'(f_row) - SPAN_W'(row_ph);
    f_cb = SPAN_W'(f_col) - SPAN_W'(col_ph);
    b_rb = SPAN_W'(b_row_base);
    b_cb = SPAN_W'(b_col_base);

    win        = ((f_rb + p_s) <= h_s) && ((f_cb + p_s) <= w_s);
    first      = (row_ph == '0) && (col_ph == '0);
    last       = (POOL_W'(row_ph) == (p - POOL_W'(1))) &&
                 (POOL_W'(col_ph) == (p - POOL_W'(1)));
    f_last_row = (f_rb + p2_s) > h_s;
    f_last_col = (f_cb + p2_s) > w_s;
    f_ch_last  = (32'(f_ch) + 32'd1) >= 32'(c);
    f_end      = f_last_row && f_last_col && f_ch_last;

    b_last_row = (b_rb + p2_s) > h_s;
    b_last_col = (b_cb + p2_s) > w_s;
    b_ch_last  = (32'(b_ch) + 32'd1) >= 32'(c);
    b_end      = b_last_row && b_last_col && b_ch_last;
    empty      = (p_s > h_s) || (p_s > w_s);
  end

  always_comb begin
    ctl.backward = command;
    ctl.window   = (command == CMD_FORWARD) && win;
    ctl.first    = first;
    ctl.last     = last;
    ctl.emit     = (command == CMD_BACKWARD) ? !empty : (win && last);
    ctl.pass_end = (command == CMD_BACKWARD) ? b_end : f_end;
    slot         = wcol;
    pos          = f_pos;
    channel      = (command == CMD_BACKWARD) ? b_ch : f_ch;
    cell_idx     = (command == CMD_BACKWARD) ? b_cell : f_cell;
  end

  always_comb begin
    f_row_next      = f_row;
    f_col_next      = f_col;
    row_ph_next     = row_ph;
    col_ph_next     = col_ph;
    wcol_next       = wcol;
    f_pos_next      = f_pos;
    f_ch_next       = f_ch;
    f_cell_next     = f_cell;
    b_row_base_next = b_row_base;
    b_col_base_next = b_col_base;
    b_ch_next       = b_ch;
    b_cell_next     = b_cell;

    if (take && (command == CMD_FORWARD)) begin
      f_pos_next = f_pos + POS_W'(1);
      if (win && last) begin
        f_cell_next = f_end ? '0 : f_cell + STORE_AW'(1);
      end
      if ((POOL_W'(col_ph) + POOL_W'(1)) >= p) begin
        col_ph_next = '0;
        wcol_next   = wcol + ROW_AW'(1);
      end else begin
        col_ph_next = col_ph + PHASE_W'(1);
      end
      if ((32'(f_col) + 32'd1) >= 32'(w)) begin
        f_col_next  = '0;
        col_ph_next = '0;
        wcol_next   = '0;
        if ((POOL_W'(row_ph) + POOL_W'(1)) >= p) begin
          row_ph_next = '0;
        end else begin
          row_ph_next = row_ph + PHASE_W'(1);
        end
        if ((32'(f_row) + 32'd1) >= 32'(h)) begin
          f_row_next  = '0;
          row_ph_next = '0;
          f_pos_next  = '0;
          if (f_ch_last) begin
            f_ch_next   = '0;
            f_cell_next = '0;
          end else begin
            f_ch_next = f_ch + CH_W'(1);
          end
        end else begin
          f_row_next = f_row + SIZE_W'(1);
        end
      end else begin
        f_col_next = f_col + SIZE_W'(1);
      end
    end

    if (take && (command == CMD_BACKWARD) && !empty) begin
      b_cell_next = b_end ? '0 : b_cell + STORE_AW'(1);
      if (b_last_col) begin
        b_col_base_next = '0;
        if (b_last_row) begin
          b_row_base_next = '0;
          b_ch_next       = b_ch_last ? '0 : b_ch + CH_W'(1);
        end else begin
          b_row_base_next = b_row_base + SIZE_W'(p);
        end
      end else begin
        b_col_base_next = b_col_base + SIZE_W'(p);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      f_row      <= '0;
      f_col      <= '0;
      row_ph     <= '0;
      col_ph     <= '0;
      wcol       <= '0;
      f_pos      <= '0;
      f_ch       <= '0;
      f_cell     <= '0;
      b_row_base <= '0;
      b_col_base <= '0;
      b_ch       <= '0;
      b_cell     <= '0;
    end else begin
      f_row      <= f_row_next;
      f_col      <= f_col_next;
      row_ph     <= row_ph_next;
      col_ph     <= col_ph_next;
      wcol       <= wcol_next;
      f_pos      <= f_pos_next;
      f_ch       <= f_ch_next;
      f_cell     <= f_cell_next;
      b_row_base <= b_row_base_next;
      b_col_base <= b_col_base_next;
      b_ch       <= b_ch_next;
      b_cell     <= b_cell_next;
    end
  end

endmodule

@@ hw/rtl/max_pool_with_argmax_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_pool_with_argmax_unit
// Max pooling with argmax: forward pooling into an argmax store, backward
// gradient routing to the stored positions.
//
//   channel  handshake             payload
//   input    in_valid / in_ready   command, data_value
//   output   out_valid / out_ready result_kind, result_value, result_channel,
//                                  plane_position, cell_number, pass_end
//   config   cfg_write             cfg_index, cfg_data
//
// One beat per cycle sustained while no stalled result holds the compare
// stage; a beat is registered with the read of the window row RAM and argmax
// RAM, then the compare and write-back stage loads the output register.
// Same-entry read-after-write between neighbor beats is bypassed in the RAMs.
// A stalled result holds the compare stage; beats that give no result still
// pass through it. Reset and any config write clear all counters; the RAMs
// are not cleared.
// ----------------------------------------------------------------------------
module max_pool_with_argmax_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [mpa_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [mpa_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 command,
  input  logic signed [mpa_pkg::RESULT_W-1:0]  data_value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 result_kind,
  output logic signed [mpa_pkg::RESULT_W-1:0]  result_value,
  output logic [mpa_pkg::CHAN_W-1:0]           result_channel,
  output logic [mpa_pkg::POS_W-1:0]            plane_position,
  output logic [mpa_pkg::CELL_W-1:0]           cell_number,
  output logic                                 pass_end
);
  import mpa_pkg::*;

  localparam int ROW_DEPTH   = MAX_WIDTH / 2;
  localparam int ROW_AW      = (ROW_DEPTH > 1) ? $clog2(ROW_DEPTH) : 1;
  localparam int ROW_DW      = RESULT_W + POS_W;
  localparam int STORE_DEPTH = (MAX_HEIGHT / 2) * (MAX_WIDTH / 2) * MAX_CHANNELS;
  localparam int STORE_AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CH_W        = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  mpa_cfg_t cfg;

  mpa_ctl_t            ctl0;
  logic [ROW_AW-1:0]   slot0;
  logic [POS_W-1:0]    pos0;
  logic [CH_W-1:0]     chan0;
  logic [STORE_AW-1:0] cell0;

  logic take;
  logic s1_valid;
  mpa_ctl_t            s1_ctl;
  logic [RESULT_W-1:0] s1_value;
  logic [ROW_AW-1:0]   s1_slot;
  logic [POS_W-1:0]    s1_pos;
  logic [CH_W-1:0]     s1_chan;
  logic [STORE_AW-1:0] s1_cell;

  logic [ROW_DW-1:0]      row_q;
  logic [RESULT_W-1:0]    row_max, new_max;
  logic [POS_W-1:0]       row_pos, new_pos, store_q;
  logic upd, s1_go, row_wr, out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.win_size      <= POOL_W'(2);
      cfg.image_height  <= SIZE_W'(64);
      cfg.image_width   <= SIZE_W'(64);
      cfg.channel_count <= CHANS_W'(1);
    end else if (cfg_write) begin
      case (reg_index_t'(cfg_index))
        REG_POOL_SIZE:     cfg.win_size      <= cfg_data[POOL_W-1:0];
        REG_IMAGE_HEIGHT:  cfg.image_height  <= cfg_data[SIZE_W-1:0];
        REG_IMAGE_WIDTH:   cfg.image_width   <= cfg_data[SIZE_W-1:0];
        REG_CHANNEL_COUNT: cfg.channel_count <= cfg_data[CHANS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign take = in_valid && in_ready;

  mpa_seq #(
    .ROW_AW       (ROW_AW),
    .STORE_AW     (STORE_AW),
    .CH_W         (CH_W)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .clear    (cfg_write),
    .cfg      (cfg),
    .take     (take),
    .command  (command),
    .ctl      (ctl0),
    .slot     (slot0),
    .pos      (pos0),
    .channel  (chan0),
    .cell_idx (cell0)
  );

  // compare and write-back stage
  always_comb begin
    row_max = row_q[ROW_DW-1:POS_W];
    row_pos = row_q[POS_W-1:0];
    upd     = s1_ctl.first || ($signed(s1_value) > $signed(row_max));
    new_max = upd ? s1_value : row_max;
    new_pos = upd ? s1_pos : row_pos;
    s1_go    = !s1_ctl.emit || !out_valid || out_ready;
    row_wr   = s1_valid && s1_ctl.window && s1_go;
    out_load = s1_valid && s1_ctl.emit && s1_go;
    in_ready = !s1_valid || s1_go;
  end

  mpa_ram #(
    .DEPTH (2 ** ROW_AW),
    .AW    (ROW_AW),
    .DW    (ROW_DW)
  ) u_row_ram (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (take && (command == CMD_FORWARD)),
    .rd_addr (slot0),
    .wr_en   (row_wr),
    .wr_addr (s1_slot),
    .wr_data ({new_max, new_pos}),
    .rd_data (row_q)
  );

  mpa_ram #(
    .DEPTH (STORE_DEPTH),
    .AW    (STORE_AW),
    .DW    (POS_W)
  ) u_store_ram (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (take && (command == CMD_BACKWARD)),
    .rd_addr (cell0),
    .wr_en   (row_wr && s1_ctl.last),
    .wr_addr (s1_cell),
    .wr_data (new_pos),
    .rd_data (store_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_ctl   <= ctl0;
      s1_value <= data_value;
      s1_slot  <= slot0;
      s1_pos   <= pos0;
      s1_chan  <= chan0;
      s1_cell  <= cell0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result_kind    <= s1_ctl.backward ? KIND_GRADIENT : KIND_MAX;
      result_value   <= s1_ctl.backward ? RESULT_W'(s1_value)
                                        : RESULT_W'($signed(new_max));
      result_channel <= CHAN_W'(s1_chan);
      plane_position <= s1_ctl.backward ? store_q : new_pos;
      cell_number    <= CELL_W'(s1_cell);
      pass_end       <= s1_ctl.pass_end;
    end
  end

endmodule
